// ===== rtl/core/tli_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_pkg : shared types and constants of the tilt level indicator
// Field widths, reset values, register map codes and the structs passed
// between the top level and the duty calculator.
// ----------------------------------------------------------------------------
package tli_pkg;

    localparam int ACCEL_W = 16;
    localparam int DUTY_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int THR_W   = 15;
    localparam int WIN_W   = 15;
    localparam int DWELL_W = 8;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [DUTY_W-1:0]  DUTY_MID    = 16'h8000;
    localparam logic [DUTY_W-1:0]  DUTY_RESET  = 16'h0FFF;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 8'd200;
    localparam logic [THR_W-1:0]   THR_RESET   = 15'd170;
    localparam logic [WIN_W-1:0]   WIN_RESET   = 15'd4096;
    localparam logic [DWELL_W-1:0] DWELL_RESET = 8'd100;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_WINDOW    = 2'd2;
    localparam logic [1:0] REG_DWELL     = 2'd3;

    // command codes
    localparam logic FUNC_SAMPLE    = 1'b0;
    localparam logic FUNC_CALIBRATE = 1'b1;

    typedef logic signed [ACCEL_W-1:0] t_accel;
    typedef logic [DUTY_W-1:0]         t_duty;

    typedef struct packed {
        t_duty horiz;
        t_duty vert;
    } t_duty_pair;

endpackage
`default_nettype wire

// ===== rtl/core/tli_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_ifs : word channels of the tilt level indicator
// Sample/command channel in, duty/LED channel out; valid/ready handshake.
// ----------------------------------------------------------------------------
interface tli_in_if;
    logic            valid;
    logic            ready;
    logic            func;
    tli_pkg::t_accel accel_x;
    tli_pkg::t_accel accel_y;
    tli_pkg::t_accel accel_z;

    modport source (output valid, output func, output accel_x, output accel_y,
                    output accel_z, input ready);
    modport sink   (input valid, input func, input accel_x, input accel_y,
                    input accel_z, output ready);
endinterface

interface tli_out_if;
    logic           valid;
    logic           ready;
    tli_pkg::t_duty horiz_duty;
    tli_pkg::t_duty vert_duty;
    logic           level_led;

    modport source (output valid, output horiz_duty, output vert_duty,
                    output level_led, input ready);
    modport sink   (input valid, input horiz_duty, input vert_duty,
                    input level_led, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tli_duty_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tli_duty_calc : gravity axis pick and duty mapping
// Picks the gravity axis, scales the two other axes into PWM duty units
// around mid scale and removes the calibration offsets.
// ----------------------------------------------------------------------------
module tli_duty_calc (
    input  var tli_pkg::t_accel                 i_accel_x,
    input  var tli_pkg::t_accel                 i_accel_y,
    input  var tli_pkg::t_accel                 i_accel_z,
    input  var logic [tli_pkg::GAIN_W-1:0]      i_gain,
    input  var logic [tli_pkg::THR_W-1:0]       i_threshold,
    input  var tli_pkg::t_duty_pair             i_offset,
    output tli_pkg::t_duty_pair                 o_duty
);

    // |a| > t, with -32768 handled in 17 bits
    function automatic logic exceeds(input tli_pkg::t_accel a,
                                     input logic [tli_pkg::THR_W-1:0] t);
        logic [tli_pkg::ACCEL_W:0] ext;
        logic [tli_pkg::ACCEL_W:0] mag;
        ext = {a[tli_pkg::ACCEL_W-1], a};
        mag = ext[tli_pkg::ACCEL_W] ? ((tli_pkg::ACCEL_W+1)'(0) - ext) : ext;
        return mag > {2'b00, t};
    endfunction

    logic                  w_any;
    tli_pkg::t_accel       w_h_sel;
    tli_pkg::t_accel       w_v_sel;
    logic [23:0]           w_h_prod;
    logic [23:0]           w_v_prod;
    tli_pkg::t_duty        w_h_map;
    tli_pkg::t_duty        w_v_map;

    always_comb begin
        w_any   = 1'b1;
        w_h_sel = i_accel_x;
        w_v_sel = i_accel_y;
        priority if (exceeds(i_accel_z, i_threshold)) begin
            w_h_sel = i_accel_x;
            w_v_sel = i_accel_y;
        end else if (exceeds(i_accel_x, i_threshold)) begin
            w_h_sel = i_accel_z;
            w_v_sel = i_accel_y;
        end else if (exceeds(i_accel_y, i_threshold)) begin
            w_h_sel = i_accel_x;
            w_v_sel = i_accel_z;
        end else begin
            w_any   = 1'b0;
        end
    end

    // only the low 16 bits survive, so an unsigned product is enough
    assign w_h_prod = {8'd0, w_h_sel} * {16'd0, i_gain};
    assign w_v_prod = {8'd0, w_v_sel} * {16'd0, i_gain};

    // +32768 mod 2^16 is a flip of the top bit; vertical is negated
    assign w_h_map = w_any ? (w_h_prod[15:0] ^ tli_pkg::DUTY_MID) : tli_pkg::DUTY_MID;
    assign w_v_map = w_any ? ((16'd0 - w_v_prod[15:0]) ^ tli_pkg::DUTY_MID)
                           : tli_pkg::DUTY_MID;

    assign o_duty.horiz = w_h_map - i_offset.horiz;
    assign o_duty.vert  = w_v_map - i_offset.vert;

endmodule
`default_nettype wire

// ===== rtl/core/tilt_level_indicator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_level_indicator_unit : accelerometer tilt to PWM duty and level LED
// Top level: input word register, duty/LED state, APB register file.
// ----------------------------------------------------------------------------
// Usage
//  - i_in carries one word: func = 0 is an accelerometer sample (x, y, z),
//    func = 1 folds the current duties into the calibration offsets.
//  - o_out carries one word per input word: the horizontal and vertical duty
//    and the level LED as they stand after that word took effect.
//  - An accepted word goes to the input register, then to the state
//    registers. Throughput: one word per cycle while o_out.ready stays high.
//  - The input register feeds one pass of short logic (axis pick, 16x8
//    multiply, offset subtract, window compare) straight into the state
//    registers, which double as the output register.
//  - When the receiver stalls, the result holds on o_out and one more word
//    is still taken into the input register; i_in.ready then drops.
//  - Reset (i_rst_n low, synchronous) empties both stages, sets the duties to
//    0x0FFF, clears offsets and LED, loads the dwell counter with 100 and the
//    registers with gain 200, threshold 170, window 4096, dwell 100.
//  - Registers (APB, byte address 4*i): gain, axis_threshold, level_window,
//    dwell_ticks. Write them only while the unit is idle.
// ----------------------------------------------------------------------------
module tilt_level_indicator_unit (
    input  var logic                          i_clk,
    input  var logic                          i_rst_n,
    tli_in_if.sink                            i_in,
    tli_out_if.source                         o_out,
    input  var logic                          psel,
    input  var logic                          penable,
    input  var logic                          pwrite,
    input  var logic [tli_pkg::ADDR_W-1:0]    paddr,
    input  var logic [tli_pkg::DATA_W-1:0]    pwdata,
    output logic [tli_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    // |duty - 32768| < window, exact
    function automatic logic duty_in_window(input tli_pkg::t_duty d,
                                            input logic [tli_pkg::WIN_W-1:0] w);
        logic [tli_pkg::DUTY_W:0] diff;
        logic [tli_pkg::DUTY_W:0] mag;
        diff = {1'b0, d} - {1'b0, tli_pkg::DUTY_MID};
        mag  = diff[tli_pkg::DUTY_W] ? ((tli_pkg::DUTY_W+1)'(0) - diff) : diff;
        return mag < {2'b00, w};
    endfunction

    // ---------------- register file ----------------
    logic [tli_pkg::GAIN_W-1:0]  r_gain;
    logic [tli_pkg::THR_W-1:0]   r_threshold;
    logic [tli_pkg::WIN_W-1:0]   r_window;
    logic [tli_pkg::DWELL_W-1:0] r_dwell_ticks;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain        <= tli_pkg::GAIN_RESET;
            r_threshold   <= tli_pkg::THR_RESET;
            r_window      <= tli_pkg::WIN_RESET;
            r_dwell_ticks <= tli_pkg::DWELL_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                tli_pkg::REG_GAIN:      r_gain        <= pwdata[tli_pkg::GAIN_W-1:0];
                tli_pkg::REG_THRESHOLD: r_threshold   <= pwdata[tli_pkg::THR_W-1:0];
                tli_pkg::REG_WINDOW:    r_window      <= pwdata[tli_pkg::WIN_W-1:0];
                tli_pkg::REG_DWELL:     r_dwell_ticks <= pwdata[tli_pkg::DWELL_W-1:0];
                default:                r_gain        <= r_gain;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            tli_pkg::REG_GAIN:      prdata = {24'd0, r_gain};
            tli_pkg::REG_THRESHOLD: prdata = {17'd0, r_threshold};
            tli_pkg::REG_WINDOW:    prdata = {17'd0, r_window};
            tli_pkg::REG_DWELL:     prdata = {24'd0, r_dwell_ticks};
            default:                prdata = '0;
        endcase
    end

    // ---------------- input word register ----------------
    logic            r_in_valid;
    logic            r_in_func;
    tli_pkg::t_accel r_in_x;
    tli_pkg::t_accel r_in_y;
    tli_pkg::t_accel r_in_z;
    logic            r_out_valid;
    logic            w_in_acc;
    logic            w_adv;     // input word resolves into state / output

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign w_in_acc    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_in_acc || (r_in_valid && !w_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_func <= i_in.func;
            r_in_x    <= i_in.accel_x;
            r_in_y    <= i_in.accel_y;
            r_in_z    <= i_in.accel_z;
        end
    end

    // ---------------- duty / LED state ----------------
    // The state registers change only when a word advances, which is exactly
    // when the output slot is loaded, so they drive o_out directly.
    tli_pkg::t_duty_pair         r_duty;
    tli_pkg::t_duty_pair         r_offset;
    logic [tli_pkg::DWELL_W-1:0] r_dwell;
    logic                        r_led;

    tli_pkg::t_duty_pair         w_new_duty;
    tli_pkg::t_duty_pair         n_duty;
    tli_pkg::t_duty_pair         n_offset;
    logic [tli_pkg::DWELL_W-1:0] n_dwell;
    logic                        n_led;
    logic                        w_level;

    tli_duty_calc u_duty_calc (
        .i_accel_x   (r_in_x),
        .i_accel_y   (r_in_y),
        .i_accel_z   (r_in_z),
        .i_gain      (r_gain),
        .i_threshold (r_threshold),
        .i_offset    (r_offset),
        .o_duty      (w_new_duty)
    );

    assign w_level = duty_in_window(w_new_duty.horiz, r_window)
                  && duty_in_window(w_new_duty.vert, r_window);

    always_comb begin
        n_duty   = r_duty;
        n_offset = r_offset;
        n_dwell  = r_dwell;
        n_led    = r_led;
        unique case (r_in_func)
            tli_pkg::FUNC_CALIBRATE: begin
                // offset += duty - 32768
                n_offset.horiz = (r_duty.horiz + r_offset.horiz) ^ tli_pkg::DUTY_MID;
                n_offset.vert  = (r_duty.vert + r_offset.vert) ^ tli_pkg::DUTY_MID;
            end
            default: begin
                n_duty = w_new_duty;
                if (!w_level) begin
                    n_dwell = r_dwell_ticks;
                    n_led   = 1'b0;
                end else if (r_dwell == '0) begin
                    n_dwell = r_dwell_ticks;
                    n_led   = 1'b1;
                end else begin
                    n_dwell = r_dwell - (tli_pkg::DWELL_W)'(1);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty.horiz  <= tli_pkg::DUTY_RESET;
            r_duty.vert   <= tli_pkg::DUTY_RESET;
            r_offset      <= '0;
            r_dwell       <= tli_pkg::DWELL_RESET;
            r_led         <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_out_valid <= w_adv || (r_out_valid && !o_out.ready);
            if (w_adv) begin
                r_duty   <= n_duty;
                r_offset <= n_offset;
                r_dwell  <= n_dwell;
                r_led    <= n_led;
            end
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.horiz_duty = r_duty.horiz;
    assign o_out.vert_duty  = r_duty.vert;
    assign o_out.level_led  = r_led;

    // ---------------- checks ----------------
    a_cal_keeps_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_func == tli_pkg::FUNC_CALIBRATE) |=> $stable(r_duty))
        else $error("calibrate changed the duty registers");

    a_led_by_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_led) || $fell(r_led)) |->
            $past(w_adv && r_in_func == tli_pkg::FUNC_SAMPLE))
        else $error("level LED moved without a sample");

    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_adv))
        else $error("result appeared without an input word");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_x) && $stable(r_in_func)))
        else $error("stalled input word lost");

endmodule
`default_nettype wire

// ===== test/tilt_level_indicator_unit_test.sv =====
// ----------------------------------------------------------------------------
// tilt_level_indicator_unit_test : self-checking bench of the tilt unit
// Drives sample and calibrate words through the input channel, predicts the
// duty pair and level LED of every word in a local model, and compares each
// output word field by field. Covers register writes and read-back, directed
// corner words, then random runs of level-ish samples, noise and calibrates
// over several register settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tilt_level_indicator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tli_pkg::*;

    // ------------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------------
    // one output word as the model sees it
    typedef struct packed {
        t_duty horiz;
        t_duty vert;
        logic  led;
    } t_duty_word;

    // one row of the directed part; known = 1 means the expected word is
    // typed in the row, otherwise the model supplies it
    typedef struct packed {
        logic   func;
        t_accel x;
        t_accel y;
        t_accel z;
        logic   known;
        t_duty  horiz;
        t_duty  vert;
        logic   led;
    } t_stim_row;

    // ------------------------------------------------------------------------
    // Clock, reset, channels, APB
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tli_in_if  in_ch ();
    tli_out_if out_ch ();

    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tilt_level_indicator_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_duty_word pending_duties [$];   // expected output words, oldest first
    int         mismatches = 0;
    int         words_in   = 0;
    int         words_out  = 0;
    bit         quiet      = 1'b0;    // no idling on either side while set
    bit         hold_done  = 1'b0;

    // model copy of the registers
    logic [GAIN_W-1:0]  cfg_gain;
    logic [THR_W-1:0]   cfg_thr;
    logic [WIN_W-1:0]   cfg_win;
    logic [DWELL_W-1:0] cfg_dwell;

    // model copy of the unit state
    t_duty              horiz_now;
    t_duty              vert_now;
    t_duty              horiz_ofs;
    t_duty              vert_ofs;
    logic [DWELL_W-1:0] dwell_left;
    logic               led_now;

    // ------------------------------------------------------------------------
    // Directed words. Rows with known = 1 carry the expected word.
    // ------------------------------------------------------------------------
    localparam int N_ROWS = 19;
    t_stim_row dir_rows [N_ROWS] = '{
        // quiet after reset: no axis over threshold -> mid scale
        '{FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 1'b1, DUTY_MID, DUTY_MID, 1'b0},
        // z just over threshold, x and y zero -> mid scale
        '{FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd171, 1'b1, DUTY_MID, DUTY_MID, 1'b0},
        // all axes exactly at threshold: none exceeds
        '{FUNC_SAMPLE, 16'sd170, 16'sd170, 16'sd170, 1'b1, DUTY_MID, DUTY_MID, 1'b0},
        '{FUNC_SAMPLE, -16'sd170, -16'sd170, -16'sd170, 1'b1, DUTY_MID, DUTY_MID,
          1'b0},
        // negative z gravity, small tilt
        '{FUNC_SAMPLE, 16'sd1, 16'sd1, -16'sd171, 1'b0, 16'h0, 16'h0, 1'b0},
        // all axes at the extremes: z wins, products wrap
        '{FUNC_SAMPLE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_SAMPLE, 16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 16'h0, 16'h0, 1'b0},
        // x gravity
        '{FUNC_SAMPLE, 16'sd171, -16'sd5, 16'sd0, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_SAMPLE, 16'sh8000, 16'sh7FFF, 16'sd0, 1'b0, 16'h0, 16'h0, 1'b0},
        // y gravity
        '{FUNC_SAMPLE, 16'sd0, 16'sd171, 16'sd3, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_SAMPLE, 16'sd50, 16'sh8000, -16'sd100, 1'b0, 16'h0, 16'h0, 1'b0},
        // alternating bit patterns
        '{FUNC_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, 16'h0, 16'h0, 1'b0},
        // near level, then calibrate (accel fields ignored), then same sample
        '{FUNC_SAMPLE, -16'sd20, 16'sd20, 16'sd500, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_CALIBRATE, -16'sd1, -16'sd1, -16'sd1, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_SAMPLE, -16'sd20, 16'sd20, 16'sd500, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_CALIBRATE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'h0, 16'h0, 1'b0},
        // far out of the window, calibrate on it, back to quiet
        '{FUNC_SAMPLE, 16'sh7FFF, 16'sd0, 16'sh8000, 1'b0, 16'h0, 16'h0, 1'b0},
        '{FUNC_CALIBRATE, 16'sh7FFF, 16'sh8000, 16'sh5555, 1'b0, 16'h0, 16'h0,
          1'b0},
        '{FUNC_SAMPLE, 16'sd0, 16'sd0, 16'sd0, 1'b0, 16'h0, 16'h0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Tilt model
    // ------------------------------------------------------------------------
    task automatic reset_model();
        cfg_gain   = GAIN_RESET;
        cfg_thr    = THR_RESET;
        cfg_win    = WIN_RESET;
        cfg_dwell  = DWELL_RESET;
        horiz_now  = DUTY_RESET;
        vert_now   = DUTY_RESET;
        horiz_ofs  = '0;
        vert_ofs   = '0;
        dwell_left = DWELL_RESET;
        led_now    = 1'b0;
    endtask

    function automatic bit over_thr(t_accel a);
        int v;
        int t;
        v = int'(a);
        t = int'(cfg_thr);
        return (v > t) || (v < -t);
    endfunction

    // (+/- a * gain + mid) mod 2^16
    function automatic t_duty axis_to_duty(t_accel a, bit negate);
        logic [31:0] p;
        p = 32'(int'(a)) * {24'h0, cfg_gain};
        if (negate)
            p = 32'h0 - p;
        return t_duty'(p + {16'h0, DUTY_MID});
    endfunction

    // strict window around mid scale, no wrap
    function automatic bit near_mid(t_duty d);
        int v;
        int w;
        v = int'({16'h0, d});
        w = int'(cfg_win);
        return (v < 32768 + w) && (v > 32768 - w);
    endfunction

    // apply one word to the model state, return the word it should emit
    function automatic t_duty_word tilt_update(logic func, t_accel x, t_accel y,
                                               t_accel z);
        t_duty h;
        t_duty v;
        if (func == FUNC_CALIBRATE) begin
            horiz_ofs = horiz_now + DUTY_MID + horiz_ofs;
            vert_ofs  = vert_now + DUTY_MID + vert_ofs;
        end else begin
            if (over_thr(z)) begin
                h = axis_to_duty(x, 1'b0);
                v = axis_to_duty(y, 1'b1);
            end else if (over_thr(x)) begin
                h = axis_to_duty(z, 1'b0);
                v = axis_to_duty(y, 1'b1);
            end else if (over_thr(y)) begin
                h = axis_to_duty(x, 1'b0);
                v = axis_to_duty(z, 1'b1);
            end else begin
                h = DUTY_MID;
                v = DUTY_MID;
            end
            horiz_now = h - horiz_ofs;
            vert_now  = v - vert_ofs;
            if (near_mid(horiz_now) && near_mid(vert_now)) begin
                if (dwell_left == '0) begin
                    led_now    = 1'b1;
                    dwell_left = cfg_dwell;
                end else begin
                    dwell_left = dwell_left - DWELL_W'(1);
                end
            end else begin
                dwell_left = cfg_dwell;
                led_now    = 1'b0;
            end
        end
        return '{horiz: horiz_now, vert: vert_now, led: led_now};
    endfunction

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch %s: got 0x%0h want 0x%0h (output word %0d)",
                 what, got, want, words_out);
    endtask

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // random raw axis value, extremes favored now and then
    function automatic t_accel pick_raw();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return t_accel'(16'($urandom));
        endcase
    endfunction

    // value in [-lim, lim]
    function automatic t_accel pick_small(int lim);
        return t_accel'(16'(int'($urandom_range(0, 2 * lim)) - lim));
    endfunction

    // one word on the input channel; prediction is taken at acceptance
    task automatic send_word(input logic func, input t_accel x, input t_accel y,
                             input t_accel z, input bit known,
                             input t_duty_word typed);
        int         gap;
        t_duty_word predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.func    = func;
        in_ch.accel_x = x;
        in_ch.accel_y = y;
        in_ch.accel_z = z;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        words_in++;
        predicted = tilt_update(func, x, y, z);
        pending_duties.push_back(known ? typed : predicted);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // read back all four registers against the model copy
    task automatic check_regs();
        logic [DATA_W-1:0] want;
        logic [1:0]        idx;
        for (int i = 0; i < 4; i++) begin
            idx = 2'(i);
            case (idx)
                REG_GAIN:      want = DATA_W'(cfg_gain);
                REG_THRESHOLD: want = DATA_W'(cfg_thr);
                REG_WINDOW:    want = DATA_W'(cfg_win);
                default:       want = DATA_W'(cfg_dwell);
            endcase
            @(negedge i_clk);
            psel    = 1'b1;
            pwrite  = 1'b0;
            penable = 1'b0;
            paddr   = {idx, 2'b00};
            @(negedge i_clk);
            penable = 1'b1;
            @(posedge i_clk);
            while (!pready)
                @(posedge i_clk);
            if (prdata !== want)
                flag_mismatch($sformatf("register %0d read", i), int'(prdata),
                              int'(want));
            @(negedge i_clk);
            psel    = 1'b0;
            penable = 1'b0;
        end
    endtask

    // wait until the unit is idle, write all registers (junk above each
    // field to check masking), then read them back
    task automatic set_config(input int g, input int thr, input int win, input int dw);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_duties.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        apb_write(REG_GAIN,      ($urandom & ~32'hFF)   | DATA_W'(g));
        apb_write(REG_THRESHOLD, ($urandom & ~32'h7FFF) | DATA_W'(thr));
        apb_write(REG_WINDOW,    ($urandom & ~32'h7FFF) | DATA_W'(win));
        apb_write(REG_DWELL,     ($urandom & ~32'hFF)   | DATA_W'(dw));
        cfg_gain  = GAIN_W'(g);
        cfg_thr   = THR_W'(thr);
        cfg_win   = WIN_W'(win);
        cfg_dwell = DWELL_W'(dw);
        check_regs();
    endtask

    // Random words. Mostly runs of level-ish samples (gravity axis well over
    // threshold, the other two small enough to land near the window edges),
    // some long enough to get past the dwell count; then noise bursts, and
    // calibrates right after level runs so the offsets stay usable.
    task automatic run_random(input int n_words);
        int     left;
        int     run;
        int     pick;
        int     span;
        int     lim;
        int     lim_thr;
        int     thr;
        bit     last_level;
        t_accel g;
        t_accel a;
        t_accel b;
        t_accel c;
        left       = n_words;
        last_level = 1'b0;
        thr        = int'(cfg_thr);
        span       = (cfg_gain == '0) ? 2000 : int'(cfg_win) / int'(cfg_gain);
        lim        = (span + 1 > 32767) ? 32767 : span + 1;
        lim_thr    = (lim > thr) ? thr : lim;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                run = $urandom_range(1, int'(cfg_dwell) + 12);
                for (int k = 0; k < run && left > 0; k++) begin
                    if (thr >= 32767) begin
                        g = 16'sh8000;
                    end else begin
                        g = t_accel'(16'($urandom_range(thr + 1, 32767)));
                        if ($urandom_range(0, 1) == 1)
                            g = -g;
                    end
                    case ($urandom_range(0, 9))
                        0, 1: begin      // x is gravity, z must stay under
                            a = pick_small(lim_thr);
                            b = pick_small(lim);
                            send_word(FUNC_SAMPLE, g, b, a, 1'b0, '0);
                        end
                        2: begin         // y is gravity, x and z stay under
                            a = pick_small(lim_thr);
                            c = pick_small(lim_thr);
                            send_word(FUNC_SAMPLE, a, g, c, 1'b0, '0);
                        end
                        default: begin   // z is gravity
                            a = pick_small(lim);
                            b = pick_small(lim);
                            send_word(FUNC_SAMPLE, a, b, g, 1'b0, '0);
                        end
                    endcase
                    left--;
                end
                last_level = 1'b1;
            end else if (pick < 90 || !last_level) begin
                run = $urandom_range(1, 4);
                for (int k = 0; k < run && left > 0; k++) begin
                    send_word(FUNC_SAMPLE, pick_raw(), pick_raw(), pick_raw(),
                              1'b0, '0);
                    left--;
                end
                last_level = 1'b0;
            end else begin
                send_word(FUNC_CALIBRATE, pick_raw(), pick_raw(), pick_raw(),
                          1'b0, '0);
                left--;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random ready, one long hold-off while words keep coming
    // ------------------------------------------------------------------------
    initial begin : sink_side
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && words_in >= 500) begin
                // long hold: the unit fills its input register and stalls i_in
                hold_done    = 1'b1;
                out_ch.ready = 1'b0;
                repeat (80) @(negedge i_clk);
            end
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else begin
                out_ch.ready = 1'b1;
                stall_left   = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output check: each accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : duty_check
        t_duty_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            words_out++;
            if (pending_duties.size() == 0) begin
                flag_mismatch("word with nothing pending", int'(out_ch.horiz_duty), 0);
            end else begin
                want = pending_duties.pop_front();
                if (out_ch.horiz_duty !== want.horiz)
                    flag_mismatch("horiz_duty", int'(out_ch.horiz_duty),
                                  int'(want.horiz));
                if (out_ch.vert_duty !== want.vert)
                    flag_mismatch("vert_duty", int'(out_ch.vert_duty),
                                  int'(want.vert));
                if (out_ch.level_led !== want.led)
                    flag_mismatch("level_led", int'(out_ch.level_led),
                                  int'(want.led));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_duty_word typed;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_SAMPLE;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        reset_model();

        // reset held low from time zero, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset values of the registers
        check_regs();

        // directed words under the reset settings
        foreach (dir_rows[i]) begin
            typed = '{horiz: dir_rows[i].horiz, vert: dir_rows[i].vert,
                      led: dir_rows[i].led};
            send_word(dir_rows[i].func, dir_rows[i].x, dir_rows[i].y,
                      dir_rows[i].z, dir_rows[i].known, typed);
        end

        // low extremes: zero gain, every axis counts, empty window, no dwell
        set_config(0, 0, 0, 0);
        run_random(120);

        // high extremes: long dwell gets a long run; receiver hold lands here
        set_config(255, 32767, 32767, 255);
        run_random(400);

        // reset settings, no idling on either side
        quiet = 1'b1;
        set_config(200, 170, 4096, 100);
        run_random(200);
        quiet = 1'b0;

        // random settings with short dwell so the LED toggles often
        repeat (3) begin
            set_config($urandom_range(1, 255), $urandom_range(0, 3000),
                       $urandom_range(64, 20000), $urandom_range(0, 15));
            run_random(190);
        end

        // window of one: only exact mid scale counts as level
        set_config(255, 0, 1, 1);
        run_random(60);

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (pending_duties.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Run limit, several times the slowest legal run
    // ------------------------------------------------------------------------
    initial begin : run_limit
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
